[rtl/core/ic2d_pkg.sv]
// ----------------------------------------------------------------------------
// ic2d_pkg
// Shared constants and types for the zero-padded 2D image convolution block.
// ----------------------------------------------------------------------------
package ic2d_pkg;

  localparam int unsigned KERNEL_SIZE   = 5;
  localparam int unsigned HALF          = KERNEL_SIZE / 2;
  localparam int unsigned COEF_BITS     = 12;
  localparam int unsigned SLOT_BITS     = 12;
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned WREG_W  = 11;
  localparam int unsigned HREG_W  = 13;
  localparam int unsigned KROW_W  = SLOT_BITS * KERNEL_SIZE;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned PROD_W    = PIX_W + COEF_BITS + 1;
  localparam int unsigned SUM_W     = PROD_W + 5;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_KROW0  = 3'd2;
  localparam logic [IDX_W-1:0] REG_KROW1  = 3'd3;
  localparam logic [IDX_W-1:0] REG_KROW2  = 3'd4;
  localparam logic [IDX_W-1:0] REG_KROW3  = 3'd5;
  localparam logic [IDX_W-1:0] REG_KROW4  = 3'd6;

  localparam logic [WREG_W-1:0] WIDTH_RST  = 11'd512;
  localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd512;
  localparam logic [KROW_W-1:0] KROW_CTR_RST =
    KROW_W'(256) << (SLOT_BITS * HALF);

  typedef logic [KERNEL_SIZE-2:0][PIX_W-1:0] lb_entry_t;
  typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] win_col_t;

endpackage

[rtl/core/image_conv2d_zero_pad.sv]
// ----------------------------------------------------------------------------
// image_conv2d_zero_pad
// 5x5 convolution of a raster pixel stream with zero padding at the borders.
// ----------------------------------------------------------------------------
// Input channel: one transaction per pixel in raster order (func_i = 0), or a
// drain tick (func_i = 1) after the frame. Output channel: one transaction per
// output pixel with rounded, saturated magnitude and a frame end flag.
// Outputs lag the input by 2*W+2 positions; drain ticks flush the last ones.
// Throughput is one transaction per cycle while in_stall_o is low. The pipeline
// registers, from the accepting edge to the output register: line buffer read,
// multiply, row sums, total sum, round and saturate.
// The line buffer is one memory of MAX_WIDTH entries holding four rows per
// column; each step reads and writes back the column, with forwarding when
// consecutive steps hit the same column (one pixel per row).
// For frames shorter than the output lag the block holds in_stall_o high once
// the frame is complete, to run ahead the line buffer until the lag is reached.
// Reset restores a 512x512 frame and the identity kernel; the line buffer is
// not cleared. A stall on the output freezes the whole pipeline and raises
// in_stall_o in the same cycle. Width or height writes restart the frame.
// ----------------------------------------------------------------------------
module image_conv2d_zero_pad #(
  parameter int unsigned MAX_WIDTH = ic2d_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [ic2d_pkg::PIX_W-1:0]   pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ic2d_pkg::PIX_W-1:0]   pixel_out_o,
  output logic                         saturated_o,
  output logic                         frame_end_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ic2d_pkg::ADDR_W-1:0]  paddr,
  input  logic [ic2d_pkg::DATA_W-1:0]  pwdata,
  output logic [ic2d_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import ic2d_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned LW = WW + 1;
  localparam int unsigned RW = HREG_W;
  localparam int unsigned K  = KERNEL_SIZE;

  // configuration
  logic [WREG_W-1:0]  width_q;
  logic [HREG_W-1:0]  height_q;
  logic [KROW_W-1:0]  kern_q [K];
  logic               cfg_wr;
  logic               size_wr;
  logic [IDX_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:3];
  assign size_wr = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      for (int i = 0; i < K; i++) begin
        kern_q[i] <= (i == HALF) ? KROW_CTR_RST : '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_q <= pwdata[WREG_W-1:0];
        REG_HEIGHT: height_q <= pwdata[HREG_W-1:0];
        REG_KROW0:  kern_q[0] <= pwdata[KROW_W-1:0];
        REG_KROW1:  kern_q[1] <= pwdata[KROW_W-1:0];
        REG_KROW2:  kern_q[2] <= pwdata[KROW_W-1:0];
        REG_KROW3:  kern_q[3] <= pwdata[KROW_W-1:0];
        REG_KROW4:  kern_q[4] <= pwdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      REG_KROW0:  prdata = DATA_W'(kern_q[0]);
      REG_KROW1:  prdata = DATA_W'(kern_q[1]);
      REG_KROW2:  prdata = DATA_W'(kern_q[2]);
      REG_KROW3:  prdata = DATA_W'(kern_q[3]);
      REG_KROW4:  prdata = DATA_W'(kern_q[4]);
      default:    prdata = '0;
    endcase
  end

  // effective frame size
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [LW-1:0] lag;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign lag = LW'(w_eff) * LW'(HALF) + LW'(HALF);

  // step control
  logic [CW-1:0] in_col_q;
  logic [RW-1:0] in_row_q;
  logic [CW-1:0] out_col_q;
  logic [RW-1:0] out_row_q;
  logic [LW-1:0] lead_q;
  logic          out_valid_q;
  logic          adv, complete, catchup, acc;
  logic          step_pix, step_drn, step_cu, step, emit, last;

  assign adv        = !out_valid_q || !out_stall_i;
  assign complete   = in_row_q >= h_eff;
  assign catchup    = complete && (lead_q < lag);
  assign in_stall_o = !adv || catchup;
  assign acc        = in_valid_i && !in_stall_o;
  assign step_pix   = acc && !func_i && !complete;
  assign step_drn   = acc && complete;
  assign step_cu    = adv && catchup;
  assign step       = step_pix || step_drn || step_cu;
  assign emit       = (step_pix && lead_q == lag) || step_drn;
  assign last       = (out_row_q == h_eff - RW'(1)) &&
                      (WW'(out_col_q) == w_eff - WW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else if (size_wr || (step && emit && last)) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else if (step) begin
      if (WW'(in_col_q) == w_eff - WW'(1)) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + RW'(1);
      end else begin
        in_col_q <= in_col_q + CW'(1);
      end
      if (emit) begin
        if (WW'(out_col_q) == w_eff - WW'(1)) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end else begin
        lead_q <= lead_q + LW'(1);
      end
    end
  end

  // border masks for the output position
  logic [K-1:0] rowv, colv;

  always_comb begin
    int r, c;
    for (int i = 0; i < K; i++) begin
      r = int'(out_row_q) + i - int'(HALF);
      c = int'(out_col_q) + i - int'(HALF);
      rowv[i] = (r >= 0) && (r < int'(h_eff));
      colv[i] = (c >= 0) && (c < int'(w_eff));
    end
  end

  // line buffer read stage
  lb_entry_t  line_mem [MAX_WIDTH];
  lb_entry_t  rd_q, fwd_data_q, old_ent, wdata;
  logic       a_valid_q, a_emit_q, a_last_q, fwd_q;
  logic [PIX_W-1:0] a_pix_q;
  logic [CW-1:0]    a_col_q;
  logic [K-1:0]     a_rowv_q, a_colv_q;

  always_ff @(posedge clk_i) begin
    if (adv && step) begin
      rd_q <= line_mem[in_col_q];
    end
    if (adv && a_valid_q) begin
      line_mem[a_col_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (adv) begin
      a_valid_q <= step;
      fwd_q     <= step && a_valid_q && (a_col_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_emit_q   <= emit;
      a_last_q   <= last;
      a_pix_q    <= step_pix ? pixel_in_i : '0;
      a_col_q    <= in_col_q;
      a_rowv_q   <= rowv;
      a_colv_q   <= colv;
      fwd_data_q <= wdata;
    end
  end

  // window update and products
  win_col_t   win_q [K];
  win_col_t   win_d [K];
  win_col_t   new_col;
  logic signed [PROD_W-1:0] prod_d [K][K];

  always_comb begin
    old_ent  = fwd_q ? fwd_data_q : rd_q;
    wdata[0] = a_pix_q;
    for (int k = 1; k < K - 1; k++) begin
      wdata[k] = old_ent[k-1];
    end
    new_col[K-1] = a_pix_q;
    for (int k = 0; k < K - 1; k++) begin
      new_col[K-2-k] = old_ent[k];
    end
    for (int n = 0; n < K; n++) begin
      win_d[n] = win_q[n];
    end
    if (a_valid_q) begin
      for (int n = 0; n < K - 1; n++) begin
        win_d[n] = win_q[n+1];
      end
      win_d[K-1] = new_col;
    end
  end

  always_comb begin
    logic [PIX_W-1:0]     tap;
    logic [COEF_BITS-1:0] cf;
    for (int m = 0; m < K; m++) begin
      for (int n = 0; n < K; n++) begin
        tap = (a_rowv_q[m] && a_colv_q[n]) ? win_d[n][m] : '0;
        cf  = kern_q[K-1-m][SLOT_BITS*(K-1-n) +: COEF_BITS];
        prod_d[m][n] = $signed({{(PROD_W-PIX_W){1'b0}}, tap}) *
                       $signed({{(PROD_W-COEF_BITS){cf[COEF_BITS-1]}}, cf});
      end
    end
  end

  logic                     p_valid_q, r_valid_q, s_valid_q;
  logic                     p_last_q, r_last_q, s_last_q;
  logic signed [PROD_W-1:0] p_prod_q [K][K];
  logic signed [SUM_W-1:0]  r_sum_q [K];
  logic signed [SUM_W-1:0]  r_sum_d [K];
  logic signed [SUM_W-1:0]  s_sum_q, s_sum_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    for (int m = 0; m < K; m++) begin
      r_sum_d[m] = '0;
      for (int n = 0; n < K; n++) begin
        r_sum_d[m] = r_sum_d[m] + SUM_W'(p_prod_q[m][n]);
      end
    end
    s_sum_d = '0;
    for (int m = 0; m < K; m++) begin
      s_sum_d = s_sum_d + r_sum_q[m];
    end
  end

  // round and saturate
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] rnd;
  logic [PIX_W-1:0] pix_out_q;
  logic             sat_q, fend_q;

  assign mag = s_sum_q[SUM_W-1] ? SUM_W'(-s_sum_q) : SUM_W'(s_sum_q);
  assign rnd = (mag + SUM_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      r_valid_q   <= 1'b0;
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q   <= a_valid_q && a_emit_q;
      r_valid_q   <= p_valid_q;
      s_valid_q   <= r_valid_q;
      out_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_prod_q  <= prod_d;
      p_last_q  <= a_last_q;
      r_sum_q   <= r_sum_d;
      r_last_q  <= p_last_q;
      s_sum_q   <= s_sum_d;
      s_last_q  <= r_last_q;
      sat_q     <= rnd > SUM_W'(255);
      pix_out_q <= (rnd > SUM_W'(255)) ? '1 : rnd[PIX_W-1:0];
      fend_q    <= s_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_out_q;
  assign saturated_o = sat_q;
  assign frame_end_o = fend_q;

endmodule
